// ===== src/grbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared package for the greedy row bin packer.
// Holds fixed field widths, codes and the controller/datapath structs. No dependencies.
package grbp_pkg;

    localparam int NNZ_W      = 32;
    localparam int VALUE_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int NUM_BINS_W = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // operation codes of an input beat
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // result kinds
    localparam logic KIND_ROW  = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY = 8'd1;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic start;
        logic out_load;
        logic div_step;
        logic ord_step;
        logic edge_step;
        logic rk_keyl;
        logic rk_scan;
        logic rk_wr;
        logic bl_clr;
        logic as_cnt;
        logic as_key;
        logic as_scan;
        logic as_wr;
        logic gr_scan;
        logic pack_done;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic id_mode;
        logic out_busy;
        logic div_done;
        logic ia_last;
        logic bb_last;
        logic row_scan_done;
        logic bin_scan_done;
    } stat_t;

endpackage

// ===== src/grbp_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the row bin packer: request, response and config write.
// Depends on grbp_pkg for field widths.
interface grbp_req_if import grbp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             op;
    logic [NNZ_W-1:0] row_nnz;
    logic             last_row;
    modport source (output valid, op, row_nnz, last_row, input ready);
    modport sink   (input valid, op, row_nnz, last_row, output ready);
endinterface

interface grbp_rsp_if import grbp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic                last_result;
    modport source (output valid, kind, value, status, last_result, input ready);
    modport sink   (input valid, kind, value, status, last_result, output ready);
endinterface

interface grbp_cfg_if import grbp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/greedy_row_bin_packer_core.sv =====
`timescale 1ns / 1ps
// Load beat: the row count is stored on accept. Fetch beat: the fetch state loads the result
// register; next beat taken once the result is gone. One beat in flight at a time.
// Greedy packing after the last row: rank sort (one count-store read per compare),
// then least-load assignment and bin grouping.
// Identity packing: chunk division, row order, then edge table. Reset clears control state only;
// memories hold garbage until a run writes them.
module greedy_row_bin_packer_core import grbp_pkg::*; #(
    parameter int ROWS_MAX = 1024,
    parameter int BINS_MAX = 32
) (
    input logic        clk,
    input logic        rst_n,
    grbp_req_if.sink   req,
    grbp_rsp_if.source rsp,
    grbp_cfg_if.sink   cfg
);

    cmd_t  cmd;
    stat_t st;

    // config port never stalls
    assign cfg.ready = 1'b1;

    grbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_last  (req.last_row),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    grbp_datapath #(
        .ROWS_MAX (ROWS_MAX),
        .BINS_MAX (BINS_MAX)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .cfg_we      (cfg.valid && cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .row_nnz     (req.row_nnz),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .kind        (rsp.kind),
        .value       (rsp.value),
        .status      (rsp.status),
        .last_result (rsp.last_result)
    );

    // block-level checks
    a_accept_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !rsp.valid)
        else $error("beat accepted while a result is pending");
    a_last_is_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.last_result) |-> (rsp.kind == KIND_EDGE))
        else $error("final result is not a bin edge");
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.op == OP_FETCH)) |=> !req.ready)
        else $error("second beat taken during a fetch");
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_EMPTY)) |-> (rsp.value == '0) && !rsp.last_result)
        else $error("empty result carries data");

endmodule

// ===== src/grbp_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine of the row bin packer.
// Depends on grbp_pkg (cmd_t, stat_t, op codes).
module grbp_ctrl import grbp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  in_op,
    input  logic  in_last,
    output logic  in_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [15:0] {
        S_IDLE    = 16'h0001,
        S_FETCH   = 16'h0002,
        S_ID_DIV  = 16'h0004,
        S_ID_ORD  = 16'h0008,
        S_EDGE    = 16'h0010,
        S_RK_KEY  = 16'h0020,
        S_RK_KEYL = 16'h0040,
        S_RK_SCAN = 16'h0080,
        S_RK_WR   = 16'h0100,
        S_BL_CLR  = 16'h0200,
        S_AS_RD   = 16'h0400,
        S_AS_CNT  = 16'h0800,
        S_AS_KEY  = 16'h1000,
        S_AS_SCAN = 16'h2000,
        S_AS_WR   = 16'h4000,
        S_GR      = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE) && !st.out_busy;
    assign accept   = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_op == OP_FETCH)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                        if (in_last)
                        begin
                            cmd.start  = 1'b1;
                            state_next = st.id_mode ? S_ID_DIV : S_RK_KEY;
                        end
                    end
                end
            end
            S_FETCH:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_IDLE;
            end
            S_ID_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = S_ID_ORD;
                end
            end
            S_ID_ORD:
            begin
                cmd.ord_step = 1'b1;
                if (st.ia_last)
                begin
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                cmd.edge_step = 1'b1;
                if (st.bb_last)
                begin
                    cmd.pack_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_RK_KEY:
            begin
                state_next = S_RK_KEYL;
            end
            S_RK_KEYL:
            begin
                cmd.rk_keyl = 1'b1;
                state_next  = S_RK_SCAN;
            end
            S_RK_SCAN:
            begin
                cmd.rk_scan = 1'b1;
                if (st.row_scan_done)
                begin
                    state_next = S_RK_WR;
                end
            end
            S_RK_WR:
            begin
                cmd.rk_wr  = 1'b1;
                state_next = st.ia_last ? S_BL_CLR : S_RK_KEY;
            end
            S_BL_CLR:
            begin
                cmd.bl_clr = 1'b1;
                if (st.bb_last)
                begin
                    state_next = S_AS_RD;
                end
            end
            S_AS_RD:
            begin
                state_next = S_AS_CNT;
            end
            S_AS_CNT:
            begin
                cmd.as_cnt = 1'b1;
                state_next = S_AS_KEY;
            end
            S_AS_KEY:
            begin
                cmd.as_key = 1'b1;
                state_next = S_AS_SCAN;
            end
            S_AS_SCAN:
            begin
                cmd.as_scan = 1'b1;
                if (st.bin_scan_done)
                begin
                    state_next = S_AS_WR;
                end
            end
            S_AS_WR:
            begin
                cmd.as_wr  = 1'b1;
                state_next = st.ia_last ? S_GR : S_AS_RD;
            end
            S_GR:
            begin
                cmd.gr_scan = 1'b1;
                if (st.row_scan_done && st.bb_last)
                begin
                    cmd.pack_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // checks on the sequencer
    a_fetch_then_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> cmd.out_load && !st.out_busy)
        else $error("fetch state with output register occupied");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == S_IDLE))
        else $error("beat accepted outside idle");
    a_pack_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pack_done |=> (state_reg == S_IDLE))
        else $error("packing end did not return to idle");

endmodule

// ===== src/grbp_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the row bin packer: config registers, row/bin memories,
// rank sort, least-load search, bin grouping, edge table and result register.
// Depends on grbp_pkg.
module grbp_datapath import grbp_pkg::*; #(
    parameter int ROWS_MAX = 1024,
    parameter int BINS_MAX = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output stat_t                 st,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [NNZ_W-1:0]      row_nnz,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  kind,
    output logic [VALUE_W-1:0]    value,
    output logic [STATUS_W-1:0]   status,
    output logic                  last_result
);

    localparam int RW  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int CW  = $clog2(ROWS_MAX + 1);
    localparam int BW  = (BINS_MAX > 1) ? $clog2(BINS_MAX) : 1;
    localparam int BCW = $clog2(BINS_MAX + 1);
    localparam int PW  = $clog2(ROWS_MAX + BINS_MAX + 1);
    localparam int LW  = NNZ_W + CW;

    // memories
    logic [NNZ_W-1:0] count_mem  [ROWS_MAX];
    logic [RW-1:0]    sorted_mem [ROWS_MAX];
    logic [BW-1:0]    slot_mem   [ROWS_MAX];
    logic [RW-1:0]    order_mem  [ROWS_MAX];
    logic [LW-1:0]    load_mem   [BINS_MAX];
    logic [CW-1:0]    edge_mem   [BINS_MAX];

    // control registers
    logic [NUM_BINS_W-1:0] num_bins_reg;
    logic                  identity_reg;
    logic [CW-1:0]         m_reg;
    logic [PW-1:0]         rp_reg;
    logic                  ready_reg;
    logic                  ovf_reg;
    logic [BCW-1:0]        nb_reg;
    logic                  out_valid_reg;
    logic                  pend_reg;
    logic [CW-1:0]         ia_reg;
    logic [CW-1:0]         ja_reg;
    logic [BCW-1:0]        bb_reg;

    // working registers
    logic [NNZ_W-1:0]    key_reg;
    logic [LW-1:0]       minv_reg;
    logic [BW-1:0]       best_reg;
    logic [BW-1:0]       bd_reg;
    logic [CW-1:0]       idx_d_reg;
    logic [CW-1:0]       rank_reg;
    logic [PW-1:0]       acc_reg;
    logic [CW-1:0]       chunk_reg;
    logic [PW-1:0]       run_reg;
    logic [CW-1:0]       pos_reg;
    logic                kind_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    // memory read data
    logic [NNZ_W-1:0] cnt_rd_reg;
    logic [RW-1:0]    sr_rd_reg;
    logic [BW-1:0]    slot_rd_reg;
    logic [RW-1:0]    ord_rd_reg;
    logic [LW-1:0]    bl_rd_reg;
    logic [CW-1:0]    edge_rd_reg;

    // combinational helpers
    logic [CW-1:0]    base_m;
    logic             room;
    logic [BCW-1:0]   eff_bins;
    logic             ia_last;
    logic             bb_last;
    logic             row_scan_done;
    logic             bin_scan_done;
    logic [PW-1:0]    run_n;
    logic [CW-1:0]    edge_val;
    logic [PW-1:0]    e_idx;
    logic             gr_hit;
    logic [RW-1:0]    cnt_ra;
    logic [RW-1:0]    sr_ra;
    logic             ord_we;
    logic [RW-1:0]    ord_wa;
    logic [RW-1:0]    ord_wd;
    logic             edge_we;
    logic [CW-1:0]    edge_wd;
    logic             load_we;
    logic [BW-1:0]    load_wa;
    logic [LW-1:0]    load_wd;

    assign base_m   = ready_reg ? '0 : m_reg;
    assign room     = (32'(base_m) < ROWS_MAX);
    assign eff_bins = (num_bins_reg == '0) ? BCW'(1) :
                      (32'(num_bins_reg) > BINS_MAX) ? BCW'(BINS_MAX) : BCW'(num_bins_reg);

    assign ia_last       = (CW'(ia_reg + 1'b1) == m_reg);
    assign bb_last       = (BCW'(bb_reg + 1'b1) == nb_reg);
    assign row_scan_done = (ja_reg == m_reg) && !pend_reg;
    assign bin_scan_done = (bb_reg == nb_reg) && !pend_reg;
    assign run_n         = run_reg + PW'(chunk_reg);
    assign edge_val      = (run_n > PW'(m_reg)) ? m_reg : CW'(run_n);
    assign e_idx         = rp_reg - PW'(m_reg);
    assign gr_hit        = cmd.gr_scan && pend_reg && (BCW'(slot_rd_reg) == bb_reg);

    assign st.id_mode       = identity_reg;
    assign st.out_busy      = out_valid_reg;
    assign st.div_done      = !(acc_reg < PW'(m_reg));
    assign st.ia_last       = ia_last;
    assign st.bb_last       = bb_last;
    assign st.row_scan_done = row_scan_done;
    assign st.bin_scan_done = bin_scan_done;

    // read address selection
    always_comb
    begin
        if (cmd.as_cnt)
        begin
            cnt_ra = sr_rd_reg;
        end
        else if (cmd.rk_scan)
        begin
            cnt_ra = RW'(ja_reg);
        end
        else
        begin
            cnt_ra = RW'(ia_reg);
        end
        sr_ra = cmd.gr_scan ? RW'(ja_reg) : RW'(ia_reg);
    end

    // write port selection
    always_comb
    begin
        ord_we  = cmd.ord_step || gr_hit;
        ord_wa  = cmd.ord_step ? RW'(ia_reg) : RW'(pos_reg);
        ord_wd  = cmd.ord_step ? RW'(ia_reg) : sr_rd_reg;
        edge_we = cmd.edge_step || (cmd.gr_scan && row_scan_done);
        edge_wd = cmd.edge_step ? edge_val : pos_reg;
        load_we = cmd.bl_clr || cmd.as_wr;
        load_wa = cmd.bl_clr ? BW'(bb_reg) : best_reg;
        load_wd = cmd.bl_clr ? '0 : LW'(minv_reg + LW'(key_reg));
    end

    // row count store
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            count_mem[RW'(base_m)] <= row_nnz;
        end
        cnt_rd_reg <= count_mem[cnt_ra];
    end

    // sorted row list
    always_ff @(posedge clk)
    begin
        if (cmd.rk_wr)
        begin
            sorted_mem[RW'(rank_reg)] <= RW'(ia_reg);
        end
        sr_rd_reg <= sorted_mem[sr_ra];
    end

    // bin of each sorted slot
    always_ff @(posedge clk)
    begin
        if (cmd.as_wr)
        begin
            slot_mem[RW'(ia_reg)] <= best_reg;
        end
        slot_rd_reg <= slot_mem[RW'(ja_reg)];
    end

    // output row order
    always_ff @(posedge clk)
    begin
        if (ord_we)
        begin
            order_mem[ord_wa] <= ord_wd;
        end
        ord_rd_reg <= order_mem[RW'(rp_reg)];
    end

    // bin loads
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            load_mem[load_wa] <= load_wd;
        end
        bl_rd_reg <= load_mem[BW'(bb_reg)];
    end

    // bin edges, entry k holds edge k+1
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[BW'(bb_reg)] <= edge_wd;
        end
        edge_rd_reg <= edge_mem[BW'(e_idx - 1'b1)];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_bins_reg  <= NUM_BINS_W'(1);
            identity_reg  <= 1'b0;
            m_reg         <= '0;
            rp_reg        <= '0;
            ready_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            nb_reg        <= BCW'(1);
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            ia_reg        <= '0;
            ja_reg        <= '0;
            bb_reg        <= '0;
        end
        else
        begin
            // config writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_NUM_BINS: num_bins_reg <= cfg_data[NUM_BINS_W-1:0];
                    CFG_IDENTITY: identity_reg <= cfg_data[0];
                    default:      ;
                endcase
            end

            // row load beat
            if (cmd.load)
            begin
                ready_reg <= 1'b0;
                rp_reg    <= '0;
                if (room)
                begin
                    m_reg   <= CW'(base_m + 1'b1);
                    ovf_reg <= ready_reg ? 1'b0 : ovf_reg;
                end
                else
                begin
                    m_reg   <= base_m;
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.start)
            begin
                nb_reg   <= eff_bins;
                ia_reg   <= '0;
                ja_reg   <= '0;
                bb_reg   <= '0;
                pend_reg <= 1'b0;
            end

            // result register
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                if (ready_reg)
                begin
                    if ((rp_reg >= PW'(m_reg)) && (e_idx >= PW'(nb_reg)))
                    begin
                        ready_reg <= 1'b0;
                        m_reg     <= '0;
                        ovf_reg   <= 1'b0;
                        rp_reg    <= '0;
                    end
                    else
                    begin
                        rp_reg <= PW'(rp_reg + 1'b1);
                    end
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // identity packing
            if (cmd.div_step)
            begin
                bb_reg <= '0;
            end
            if (cmd.ord_step)
            begin
                ia_reg <= CW'(ia_reg + 1'b1);
            end
            if (cmd.edge_step)
            begin
                bb_reg <= BCW'(bb_reg + 1'b1);
            end

            // rank sort
            if (cmd.rk_keyl)
            begin
                ja_reg   <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.rk_scan || cmd.gr_scan)
            begin
                if (ja_reg < m_reg)
                begin
                    ja_reg   <= CW'(ja_reg + 1'b1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.rk_wr)
            begin
                ia_reg <= CW'(ia_reg + 1'b1);
                bb_reg <= '0;
            end

            // least-load assignment
            if (cmd.bl_clr)
            begin
                bb_reg <= BCW'(bb_reg + 1'b1);
                ia_reg <= '0;
            end
            if (cmd.as_key)
            begin
                bb_reg   <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.as_scan)
            begin
                if (bb_reg < nb_reg)
                begin
                    bb_reg   <= BCW'(bb_reg + 1'b1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
            end
            if (cmd.as_wr)
            begin
                ia_reg   <= CW'(ia_reg + 1'b1);
                bb_reg   <= '0;
                ja_reg   <= '0;
                pend_reg <= 1'b0;
            end

            // grouping: end of one bin pass
            if (cmd.gr_scan && row_scan_done)
            begin
                bb_reg <= BCW'(bb_reg + 1'b1);
                ja_reg <= '0;
            end

            if (cmd.pack_done)
            begin
                ready_reg <= 1'b1;
                rp_reg    <= '0;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg   <= '0;
            chunk_reg <= '0;
        end
        if (cmd.div_step)
        begin
            run_reg <= '0;
            if (acc_reg < PW'(m_reg))
            begin
                acc_reg   <= PW'(acc_reg + PW'(nb_reg));
                chunk_reg <= CW'(chunk_reg + 1'b1);
            end
        end
        if (cmd.edge_step)
        begin
            run_reg <= run_n;
        end

        if (cmd.rk_keyl)
        begin
            key_reg  <= cnt_rd_reg;
            rank_reg <= '0;
        end
        if (cmd.rk_scan || cmd.gr_scan)
        begin
            idx_d_reg <= ja_reg;
        end
        // rows ahead: larger count, or equal count and lower index
        if (cmd.rk_scan && pend_reg)
        begin
            if ((cnt_rd_reg > key_reg) || ((cnt_rd_reg == key_reg) && (idx_d_reg < ia_reg)))
            begin
                rank_reg <= CW'(rank_reg + 1'b1);
            end
        end

        if (cmd.as_key)
        begin
            key_reg  <= cnt_rd_reg;
            minv_reg <= '0;
            best_reg <= '0;
        end
        if (cmd.as_scan)
        begin
            bd_reg <= BW'(bb_reg);
            if (pend_reg && ((bd_reg == '0) || (bl_rd_reg < minv_reg)))
            begin
                minv_reg <= bl_rd_reg;
                best_reg <= bd_reg;
            end
        end
        if (cmd.as_wr)
        begin
            pos_reg <= '0;
        end
        if (gr_hit)
        begin
            pos_reg <= CW'(pos_reg + 1'b1);
        end

        // result payload
        if (cmd.out_load)
        begin
            if (!ready_reg)
            begin
                kind_reg   <= KIND_ROW;
                value_reg  <= '0;
                status_reg <= ST_EMPTY;
                last_reg   <= 1'b0;
            end
            else
            begin
                status_reg <= ovf_reg ? ST_DROP : ST_OK;
                if (rp_reg < PW'(m_reg))
                begin
                    kind_reg  <= KIND_ROW;
                    value_reg <= VALUE_W'(ord_rd_reg);
                    last_reg  <= 1'b0;
                end
                else
                begin
                    kind_reg  <= KIND_EDGE;
                    value_reg <= (e_idx == '0) ? '0 : VALUE_W'(edge_rd_reg);
                    last_reg  <= (e_idx >= PW'(nb_reg));
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign value       = value_reg;
    assign status      = status_reg;
    assign last_result = last_reg;

endmodule

// ===== sim/tb_greedy_row_bin_packer_core.sv =====
`timescale 1ns / 1ps
// Testbench for greedy_row_bin_packer_core: directed and random runs of row loads and fetches,
// checked beat by beat against an in-bench packing predictor. Uses grbp_pkg and grbp_if.
module tb_greedy_row_bin_packer_core;
    import grbp_pkg::*;

    localparam int ROWS_MAX = 1024;
    localparam int BINS_MAX = 32;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] value;
        logic [STATUS_W-1:0] status;
        logic               last_result;
    } result_t;

    logic clk;
    logic rst_n;

    grbp_req_if req ();
    grbp_rsp_if rsp ();
    grbp_cfg_if cfg ();

    greedy_row_bin_packer_core #(
        .ROWS_MAX(ROWS_MAX),
        .BINS_MAX(BINS_MAX)
    ) u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    // predictor state
    logic [NNZ_W-1:0]      row_nnz_mem [ROWS_MAX];
    int unsigned           sorted_idx [ROWS_MAX];
    int unsigned           row_bin [ROWS_MAX];
    logic [VALUE_W-1:0]    row_order [ROWS_MAX];
    logic [VALUE_W-1:0]    bin_edges [BINS_MAX+1];
    longint unsigned       bin_weight [BINS_MAX];
    int unsigned           loaded_rows;
    int unsigned           fetch_pos;
    bit                    results_ready;
    bit                    rows_dropped;
    int unsigned           packed_bins;
    logic [NUM_BINS_W-1:0] bins_reg;
    bit                    identity_reg;

    result_t pending_results[$];
    int      mismatch_count;
    int      results_checked;
    int      runs_packed;
    int      beats_sent;
    int      pack_wait_cycles;
    int      burst_left;
    int      stall_requests;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // packing predictor: longest-first greedy or equal chunks
    task automatic pack_rows();
        int unsigned m;
        int unsigned nb;
        int unsigned i;
        int unsigned j;
        int unsigned b;
        int unsigned best;
        int unsigned pos;
        int unsigned chunk;
        longint unsigned stop;
        logic [NNZ_W-1:0] key;
        m = loaded_rows;
        nb = (bins_reg == 0) ? 1 : ((bins_reg > BINS_MAX) ? BINS_MAX : bins_reg);
        packed_bins = nb;
        bin_edges[0] = '0;
        if (identity_reg) begin
            for (i = 0; i < m; i++) row_order[i] = i[VALUE_W-1:0];
            chunk = (m + nb - 1) / nb;
            for (b = 0; b < nb; b++)
            begin
                stop = longint'(b + 1) * chunk;
                bin_edges[b+1] = (stop > m) ? m[VALUE_W-1:0] : stop[VALUE_W-1:0];
            end
            pack_wait_cycles = chunk + 2 * m + nb + 40;
        end
        else begin
            // stable descending sort: equal counts keep row order
            for (i = 0; i < m; i++)
            begin
                key = row_nnz_mem[i];
                j = i;
                while (j > 0 && row_nnz_mem[sorted_idx[j-1]] < key)
                begin
                    sorted_idx[j] = sorted_idx[j-1];
                    j--;
                end
                sorted_idx[j] = i;
            end
            for (b = 0; b < BINS_MAX; b++) bin_weight[b] = 0;
            for (i = 0; i < m; i++)
            begin
                best = 0;
                for (b = 1; b < nb; b++)
                    if (bin_weight[b] < bin_weight[best]) best = b;
                row_bin[i] = best;
                bin_weight[best] += row_nnz_mem[sorted_idx[i]];
            end
            pos = 0;
            for (b = 0; b < nb; b++)
            begin
                for (i = 0; i < m; i++)
                    if (row_bin[i] == b)
                    begin
                        row_order[pos] = sorted_idx[i][VALUE_W-1:0];
                        pos++;
                    end
                bin_edges[b+1] = pos[VALUE_W-1:0];
            end
            pack_wait_cycles = m * (m + 5) + nb + m * (nb + 6) + nb * (m + 2) + 60;
        end
        runs_packed++;
    endtask

    // update predictor for one accepted request beat
    task automatic predict_beat(input logic op, input logic [NNZ_W-1:0] nnz, input logic last);
        result_t r;
        int unsigned e;
        if (op == OP_LOAD) begin
            if (results_ready) begin
                results_ready = 0;
                loaded_rows = 0;
                rows_dropped = 0;
                fetch_pos = 0;
            end
            if (loaded_rows < ROWS_MAX) begin
                row_nnz_mem[loaded_rows] = nnz;
                loaded_rows++;
            end
            else rows_dropped = 1;
            if (last) begin
                pack_rows();
                fetch_pos = 0;
                results_ready = 1;
            end
        end
        else if (!results_ready) begin
            r.kind = KIND_ROW;
            r.value = '0;
            r.status = ST_EMPTY;
            r.last_result = 1'b0;
            pending_results = {pending_results, r};
        end
        else begin
            r.status = rows_dropped ? ST_DROP : ST_OK;
            r.last_result = 1'b0;
            if (fetch_pos < loaded_rows) begin
                r.kind = KIND_ROW;
                r.value = row_order[fetch_pos];
            end
            else begin
                e = fetch_pos - loaded_rows;
                if (e > packed_bins) e = packed_bins;
                r.kind = KIND_EDGE;
                r.value = bin_edges[e];
                r.last_result = (e >= packed_bins);
            end
            pending_results = {pending_results, r};
            if (r.last_result) begin
                results_ready = 0;
                loaded_rows = 0;
                rows_dropped = 0;
                fetch_pos = 0;
            end
            else fetch_pos++;
        end
    endtask

    // one request beat, in bursts with random gaps
    task automatic send_beat(input logic op, input logic [NNZ_W-1:0] nnz, input logic last);
        bit rdy;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid    <= 1'b1;
        req.op       <= op;
        req.row_nnz  <= nnz;
        req.last_row <= last;
        do
        begin
            @(negedge clk);
            rdy = req.ready;
            @(posedge clk);
        end
        while (!rdy);
        beats_sent++;
        predict_beat(op, nnz, last);
    endtask

    task automatic pause_requests();
        req.valid <= 1'b0;
        burst_left = 0;
    endtask

    // register write, only once the block has drained and finished packing
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        bit rdy;
        pause_requests();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (pack_wait_cycles + 10) @(posedge clk);
        pack_wait_cycles = 0;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do
        begin
            @(negedge clk);
            rdy = cfg.ready;
            @(posedge clk);
        end
        while (!rdy);
        cfg.valid <= 1'b0;
        if (idx == CFG_NUM_BINS) bins_reg = data[NUM_BINS_W-1:0];
        else if (idx == CFG_IDENTITY) identity_reg = data[0];
    endtask

    function automatic logic [NNZ_W-1:0] pick_nnz(input int style);
        case (style)
            0: return $urandom_range(0, 7);
            1: return $urandom();
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    // whole run: load m rows, then fetch rows and edges
    task automatic load_rows(input int m, input int style);
        for (int i = 0; i < m; i++) send_beat(OP_LOAD, pick_nnz(style), i == m - 1);
    endtask

    task automatic fetch_n(input int n);
        for (int i = 0; i < n; i++) send_beat(OP_FETCH, $urandom(), $urandom_range(0, 1));
    endtask

    function automatic int run_results(input int m);
        int nb;
        nb = (bins_reg == 0) ? 1 : ((bins_reg > BINS_MAX) ? BINS_MAX : bins_reg);
        return ((m > ROWS_MAX) ? ROWS_MAX : m) + nb + 1;
    endfunction

    task automatic full_run(input int m, input int style);
        load_rows(m, style);
        fetch_n(run_results(m));
    endtask

    task automatic test_empty_and_single();
        fetch_n(2);
        send_beat(OP_LOAD, 32'd0, 1'b1);
        fetch_n(3);
        fetch_n(1);
    endtask

    task automatic test_bin_extremes();
        write_reg(CFG_NUM_BINS, 32'd0);
        full_run(5, 0);
        write_reg(CFG_NUM_BINS, 32'd32);
        full_run(3, 3);
        write_reg(CFG_NUM_BINS, 32'hFFFF_FFC7);   // 7 after masking
        full_run(12, 0);
        write_reg(CFG_NUM_BINS, 32'd63);          // clamps to the bin maximum
        full_run(40, 1);
    endtask

    task automatic test_nnz_extremes();
        write_reg(CFG_NUM_BINS, 32'd3);
        send_beat(OP_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_beat(OP_LOAD, 32'd0, 1'b0);
        send_beat(OP_LOAD, 32'hFFFF_FFFF, 1'b0);
        send_beat(OP_LOAD, 32'h5555_5555, 1'b0);
        send_beat(OP_LOAD, 32'hAAAA_AAAA, 1'b0);
        send_beat(OP_LOAD, 32'd0, 1'b1);
        fetch_n(10);
    endtask

    task automatic test_identity_chunks();
        write_reg(CFG_IDENTITY, 32'd1);
        write_reg(CFG_NUM_BINS, 32'd4);
        full_run(5, 1);                  // edges clamp to the row count
        write_reg(CFG_NUM_BINS, 32'd7);
        full_run(20, 1);
        write_reg(CFG_IDENTITY, 32'd0);
    endtask

    // load while results pending drops the old run
    task automatic test_reload_discard();
        write_reg(CFG_NUM_BINS, 32'd2);
        load_rows(6, 0);
        fetch_n(3);
        full_run(4, 3);
        fetch_n(1);
    endtask

    // more rows than the store holds; only the head of the run is fetched
    task automatic test_overflow();
        write_reg(CFG_IDENTITY, 32'd1);
        write_reg(CFG_NUM_BINS, 32'd32);
        load_rows(ROWS_MAX + 2, 1);
        fetch_n(8);
        write_reg(CFG_IDENTITY, 32'd0);
    endtask

    // long receiver hold while fetches keep coming
    task automatic test_backpressure();
        write_reg(CFG_NUM_BINS, 32'd5);
        load_rows(30, 3);
        stall_requests++;
        fetch_n(run_results(30));
    endtask

    task automatic test_random(input int items);
        int sent_at_start;
        int m;
        int style;
        int ending;
        sent_at_start = beats_sent;
        while (beats_sent - sent_at_start < items)
        begin
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 1)) write_reg(CFG_IDENTITY, $urandom_range(0, 1));
                else if ($urandom_range(0, 4) == 0)
                    write_reg(CFG_NUM_BINS, $urandom_range(0, 1) ? 32'd1 : 32'd32);
                else write_reg(CFG_NUM_BINS, $urandom());
            end
            if ($urandom_range(0, 9) == 0 && !results_ready) fetch_n(1);
            m = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 24);
            style = $urandom_range(0, 3);
            load_rows(m, style);
            ending = $urandom_range(0, 9);
            if (ending == 0) fetch_n($urandom_range(0, m));        // abandoned mid-run
            else if (ending == 1) fetch_n(run_results(m) + 1);     // one fetch too many
            else fetch_n(run_results(m));
        end
    endtask

    // receiver: changing stall patterns plus requested long holds
    always @(posedge clk or negedge rst_n)
    begin : rsp_ready_gen
        int unsigned mode_cycles;
        int unsigned mode;
        int unsigned hold_left;
        int          stalls_served;
        if (!rst_n) begin
            rsp.ready <= 1'b0;
            mode_cycles = 0;
            mode = 0;
            hold_left = 0;
            stalls_served = 0;
        end
        else begin
            if (stalls_served != stall_requests) begin
                stalls_served = stall_requests;
                hold_left = 400;
            end
            if (mode_cycles == 0) begin
                mode = $urandom_range(0, 3);
                mode_cycles = $urandom_range(50, 300);
            end
            mode_cycles--;
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else case (mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= $urandom_range(0, 1);
                2: rsp.ready <= ($urandom_range(0, 3) == 0);
                default: rsp.ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // result checker
    always @(negedge clk)
    begin : rsp_check
        result_t got;
        result_t want;
        if (rst_n && rsp.valid && rsp.ready) begin
            got.kind = rsp.kind;
            got.value = rsp.value;
            got.status = rsp.status;
            got.last_result = rsp.last_result;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result kind=%0d value=%0d status=%0d last=%0d",
                             $realtime, got.kind, got.value, got.status, got.last_result);
            end
            else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch exp kind=%0d value=%0d status=%0d last=%0d",
                                  " got kind=%0d value=%0d status=%0d last=%0d"},
                                 $realtime, want.kind, want.value, want.status,
                                 want.last_result, got.kind, got.value, got.status,
                                 got.last_result);
                end
            end
        end
    end

    initial
    begin
        #(40_000_000);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.op <= OP_LOAD;
        req.row_nnz <= '0;
        req.last_row <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_NUM_BINS;
        cfg.data <= '0;
        loaded_rows = 0;
        fetch_pos = 0;
        results_ready = 0;
        rows_dropped = 0;
        packed_bins = 1;
        bins_reg = 1;
        identity_reg = 0;
        mismatch_count = 0;
        results_checked = 0;
        runs_packed = 0;
        beats_sent = 0;
        pack_wait_cycles = 0;
        burst_left = 0;
        stall_requests = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_single();
        test_bin_extremes();
        test_nnz_extremes();
        test_identity_chunks();
        test_reload_discard();
        test_overflow();
        test_backpressure();
        test_random(200);

        pause_requests();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Run covered %0d request beats and %0d packed runs, %0d results checked.",
                 beats_sent, runs_packed, results_checked);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/grbp_pkg.sv
src/grbp_if.sv
src/grbp_ctrl.sv
src/grbp_datapath.sv
src/greedy_row_bin_packer_core.sv
sim/tb_greedy_row_bin_packer_core.sv
